// File: src/tlp_pkg.sv
// shared types and constants for the ternary literal parser
// no dependencies
`default_nettype none

package tlp_pkg;

	localparam int WORD_BITS = 64;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LO    = 8'h6f;
	localparam logic [7:0] CH_UO    = 8'h4f;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_UB    = 8'h42;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_OCT = 2'd2,
		RX_BIN = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ZERO  = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef struct packed {
		logic       is_digit;
		logic [3:0] digit;
		logic       is_under;
		logic       is_star;
		logic       is_zero;
		logic       is_prefix;
		radix_t     prefix_radix;
	} char_class_t;

endpackage

`default_nettype wire

// File: src/tlp_char_decode.sv
// character classifier: digit value, separators, wildcard and radix prefix letters
// depends on tlp_pkg
`default_nettype none

module tlp_char_decode (
	input  wire logic [7:0]          ch,
	output tlp_pkg::char_class_t     cls
);

	always_comb begin
		cls = '0;
		cls.prefix_radix = tlp_pkg::RX_DEC;
		if (ch >= tlp_pkg::CH_ZERO && ch <= tlp_pkg::CH_NINE) begin
			cls.is_digit = 1'b1;
			cls.digit = 4'(ch - tlp_pkg::CH_ZERO);
		end else if (ch >= tlp_pkg::CH_LA && ch <= tlp_pkg::CH_LF) begin
			cls.is_digit = 1'b1;
			cls.digit = 4'(ch - tlp_pkg::CH_LA + 8'd10);
		end else if (ch >= tlp_pkg::CH_UA && ch <= tlp_pkg::CH_UF) begin
			cls.is_digit = 1'b1;
			cls.digit = 4'(ch - tlp_pkg::CH_UA + 8'd10);
		end
		cls.is_under = (ch == tlp_pkg::CH_UNDER);
		cls.is_star  = (ch == tlp_pkg::CH_STAR);
		cls.is_zero  = (ch == tlp_pkg::CH_ZERO);
		if (ch == tlp_pkg::CH_LX || ch == tlp_pkg::CH_UX) begin
			cls.is_prefix = 1'b1;
			cls.prefix_radix = tlp_pkg::RX_HEX;
		end else if (ch == tlp_pkg::CH_LO || ch == tlp_pkg::CH_UO) begin
			cls.is_prefix = 1'b1;
			cls.prefix_radix = tlp_pkg::RX_OCT;
		end else if (ch == tlp_pkg::CH_LB || ch == tlp_pkg::CH_UB) begin
			cls.is_prefix = 1'b1;
			cls.prefix_radix = tlp_pkg::RX_BIN;
		end
	end

endmodule

`default_nettype wire

// File: src/tlp_accum.sv
// literal state machine and the two accumulated words; result formed combinationally
// depends on tlp_pkg
`default_nettype none

module tlp_accum (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic                           end_req,
	input  tlp_pkg::char_class_t                cls,
	output logic                                res_ok,
	output logic [tlp_pkg::WORD_BITS-1:0]       res_zero,
	output logic [tlp_pkg::WORD_BITS-1:0]       res_one
);

	tlp_pkg::phase_t phase_q, phase_d;
	tlp_pkg::radix_t radix_q, radix_d;
	logic [tlp_pkg::WORD_BITS-1:0] zero_q, zero_d;
	logic [tlp_pkg::WORD_BITS-1:0] one_q, one_d;
	logic failed_q, failed_d;

	tlp_pkg::radix_t take_rx;
	logic do_take;
	logic [3:0] dmask;
	logic [3:0] dval;
	logic [3:0] xval;
	logic [tlp_pkg::WORD_BITS-1:0] one_shift;
	logic [tlp_pkg::WORD_BITS-1:0] zero_shift;
	logic eff_dec;

	// next state
	always_comb begin
		phase_d = phase_q;
		radix_d = radix_q;
		if (step) begin
			if (end_req) begin
				phase_d = tlp_pkg::PH_START;
				radix_d = tlp_pkg::RX_DEC;
			end else begin
				unique case (phase_q)
					tlp_pkg::PH_START: begin
						if (cls.is_zero) begin
							phase_d = tlp_pkg::PH_ZERO;
						end else begin
							phase_d = tlp_pkg::PH_BODY;
							radix_d = tlp_pkg::RX_DEC;
						end
					end
					tlp_pkg::PH_ZERO: begin
						phase_d = tlp_pkg::PH_BODY;
						radix_d = cls.is_prefix ? cls.prefix_radix : tlp_pkg::RX_DEC;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// digit accumulation
	always_comb begin
		take_rx = (phase_q == tlp_pkg::PH_START || phase_q == tlp_pkg::PH_ZERO) ?
			tlp_pkg::RX_DEC : radix_q;
		do_take = step && !end_req && !failed_q &&
			!(phase_q == tlp_pkg::PH_START && cls.is_zero) &&
			!(phase_q == tlp_pkg::PH_ZERO && cls.is_prefix);
		unique case (take_rx)
			tlp_pkg::RX_HEX: begin
				dmask = 4'hf;
				one_shift = one_q << 4;
				zero_shift = zero_q << 4;
			end
			tlp_pkg::RX_OCT: begin
				dmask = 4'h7;
				one_shift = one_q << 3;
				zero_shift = zero_q << 3;
			end
			tlp_pkg::RX_BIN: begin
				dmask = 4'h1;
				one_shift = one_q << 1;
				zero_shift = zero_q << 1;
			end
			default: begin
				dmask = 4'h9;
				one_shift = (one_q << 3) + (one_q << 1);
				zero_shift = zero_q;
			end
		endcase
		dval = cls.is_star ? dmask : cls.digit;
		xval = cls.is_star ? dmask : (cls.digit ^ dmask);

		zero_d = zero_q;
		one_d = one_q;
		failed_d = failed_q;
		if (step && end_req) begin
			zero_d = '0;
			one_d = '0;
			failed_d = 1'b0;
		end else if (do_take && !cls.is_under) begin
			if (cls.is_digit || (cls.is_star && take_rx != tlp_pkg::RX_DEC)) begin
				one_d = one_shift | {{(tlp_pkg::WORD_BITS-4){1'b0}}, dval};
				if (take_rx != tlp_pkg::RX_DEC) begin
					zero_d = zero_shift | {{(tlp_pkg::WORD_BITS-4){1'b0}}, xval};
				end
			end else begin
				failed_d = 1'b1;
			end
		end
	end

	// result for an end word
	always_comb begin
		eff_dec = (phase_q == tlp_pkg::PH_ZERO) || (radix_q == tlp_pkg::RX_DEC);
		res_ok = !failed_q;
		if (failed_q) begin
			res_zero = '0;
			res_one = '0;
		end else begin
			res_one = one_q;
			res_zero = eff_dec ? ~one_q : zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlp_pkg::PH_START;
			radix_q <= tlp_pkg::RX_DEC;
			zero_q <= '0;
			one_q <= '0;
			failed_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			zero_q <= zero_d;
			one_q <= one_d;
			failed_q <= failed_d;
		end
	end

endmodule

`default_nettype wire

// File: src/ternary_literal_parser.sv
// Ternary literal parser: takes one character word per cycle and, on a word with end_req
// set, delivers ok, may_be_zero and may_be_one. Each word passes an input register and
// combinational classify-and-accumulate logic; the result for an end word is then
// registered in the output register; one word is taken every cycle, and input stalls
// only while an end word waits behind a full output register.
// depends on tlp_pkg, tlp_char_decode, tlp_accum
`default_nettype none

module ternary_literal_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     ch,
	input  wire logic                           end_req,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                ok,
	output logic [tlp_pkg::WORD_BITS-1:0]       may_be_zero,
	output logic [tlp_pkg::WORD_BITS-1:0]       may_be_one
);

	logic valid_s1;
	logic [7:0] ch_s1;
	logic end_s1;
	logic adv;
	logic step;
	logic in_fire;
	tlp_pkg::char_class_t cls;
	logic res_ok;
	logic [tlp_pkg::WORD_BITS-1:0] res_zero;
	logic [tlp_pkg::WORD_BITS-1:0] res_one;
	logic out_valid_q;

	assign adv = !end_s1 || !out_valid_q || out_ready;
	assign step = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1 <= ch;
			end_s1 <= end_req;
		end
	end

	tlp_char_decode u_decode (
		.ch  (ch_s1),
		.cls (cls)
	);

	tlp_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.end_req  (end_s1),
		.cls      (cls),
		.res_ok   (res_ok),
		.res_zero (res_zero),
		.res_one  (res_one)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && end_s1) begin
			ok <= res_ok;
			may_be_zero <= res_zero;
			may_be_one <= res_one;
		end
	end

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && end_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked end word");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (may_be_zero == '0 && may_be_one == '0))
		else $error("failed result carries nonzero words");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && end_s1))
		else $error("result without an end word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for ternary_literal_parser: a directed table of literals, then
// random literals under sender bursts and receiver stalls, scored by predictor or table
// depends on tlp_pkg and ternary_literal_parser
`default_nettype none

module tb_top;

	localparam int WB = tlp_pkg::WORD_BITS;
	localparam int RANDOM_WORDS = 600;

	typedef struct packed {
		logic          ok;
		logic [WB-1:0] zero;
		logic [WB-1:0] one;
	} result_t;

	typedef struct packed {
		logic [7:0] c;
		logic       fin;
		logic       typed;
		result_t    res;
	} row_t;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_SPARSE,
		RDY_DENSE,
		RDY_PERIODIC
	} ready_mode_t;

	localparam result_t NO_RES    = '0;
	localparam result_t EMPTY_RES = '{ok: 1'b1, zero: {WB{1'b1}}, one: {WB{1'b0}}};
	localparam result_t FAIL_RES  = '0;

	localparam row_t PLAN [27] = '{
		'{8'h00,                     1'b1, 1'b1, EMPTY_RES},
		'{tlp_pkg::CH_ZERO,          1'b0, 1'b0, NO_RES},
		'{8'hff,                     1'b1, 1'b1, EMPTY_RES},
		'{tlp_pkg::CH_ZERO,          1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_UX,            1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_LF,            1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_STAR,          1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_UNDER,         1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_LX,            1'b1, 1'b0, NO_RES},
		'{tlp_pkg::CH_ZERO,          1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_LO,            1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_ZERO + 8'd7,   1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_STAR,          1'b0, 1'b0, NO_RES},
		'{8'h00,                     1'b1, 1'b0, NO_RES},
		'{tlp_pkg::CH_ZERO,          1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_LB,            1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_ZERO + 8'd1,   1'b0, 1'b0, NO_RES},
		'{8'h00,                     1'b1, 1'b0, NO_RES},
		'{tlp_pkg::CH_ZERO,          1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_ZERO + 8'd5,   1'b0, 1'b0, NO_RES},
		'{tlp_pkg::CH_UF,            1'b0, 1'b0, NO_RES},
		'{8'h00,                     1'b1, 1'b0, NO_RES},
		'{tlp_pkg::CH_STAR,          1'b0, 1'b0, NO_RES},
		'{8'h00,                     1'b1, 1'b1, FAIL_RES},
		'{8'h00,                     1'b0, 1'b0, NO_RES},
		'{8'hff,                     1'b0, 1'b0, NO_RES},
		'{8'h00,                     1'b1, 1'b1, FAIL_RES}
	};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [7:0]    ch = 8'h00;
	logic          end_req = 1'b0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic          ok;
	logic [WB-1:0] may_be_zero;
	logic [WB-1:0] may_be_one;

	tlp_pkg::phase_t lit_phase = tlp_pkg::PH_START;
	tlp_pkg::radix_t lit_radix = tlp_pkg::RX_DEC;
	logic [WB-1:0]   lit_zero = '0;
	logic [WB-1:0]   lit_one = '0;
	logic            lit_failed = 1'b0;

	result_t       results_due [$];
	result_t       got_res;
	int            mismatch_count = 0;
	int            word_count = 0;
	int            burst_left = 0;
	ready_mode_t   ready_mode = RDY_ALWAYS;
	logic [5:0]    ready_tick = '0;

	ternary_literal_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.end_req    (end_req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.may_be_zero(may_be_zero),
		.may_be_one (may_be_one)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("ternary_literal_parser regression: fail");
		$finish;
	end

	// one character folded into both words
	function automatic void fold_char(input logic [7:0] c);
		logic [4:0] base;
		logic [3:0] d;
		logic [3:0] m;
		if (lit_failed)
			return;
		case (lit_radix)
			tlp_pkg::RX_HEX: base = 5'd16;
			tlp_pkg::RX_OCT: base = 5'd8;
			tlp_pkg::RX_BIN: base = 5'd2;
			default: base = 5'd10;
		endcase
		m = 4'(base - 5'd1);
		if (c == tlp_pkg::CH_UNDER)
			return;
		if (c >= tlp_pkg::CH_ZERO && c <= tlp_pkg::CH_NINE) begin
			d = 4'(c - tlp_pkg::CH_ZERO);
		end else if (c >= tlp_pkg::CH_LA && c <= tlp_pkg::CH_LF) begin
			d = 4'(c - tlp_pkg::CH_LA + 8'd10);
		end else if (c >= tlp_pkg::CH_UA && c <= tlp_pkg::CH_UF) begin
			d = 4'(c - tlp_pkg::CH_UA + 8'd10);
		end else if (c == tlp_pkg::CH_STAR && lit_radix != tlp_pkg::RX_DEC) begin
			d = m;
			m = 4'd0;
		end else begin
			lit_failed = 1'b1;
			return;
		end
		lit_zero = lit_zero * WB'(base) | WB'(d ^ m);
		lit_one = lit_one * WB'(base) | WB'(d);
	endfunction

	function automatic void predict_word(input logic [7:0] c, input logic fin,
			output logic done, output result_t res);
		res = '0;
		done = 1'b0;
		if (fin) begin
			if (lit_phase == tlp_pkg::PH_ZERO) begin
				lit_radix = tlp_pkg::RX_DEC;
				fold_char(tlp_pkg::CH_ZERO);
			end
			done = 1'b1;
			if (!lit_failed) begin
				res.ok = 1'b1;
				res.one = lit_one;
				res.zero = (lit_radix == tlp_pkg::RX_DEC) ? ~lit_one : lit_zero;
			end
			lit_phase = tlp_pkg::PH_START;
			lit_radix = tlp_pkg::RX_DEC;
			lit_zero = '0;
			lit_one = '0;
			lit_failed = 1'b0;
		end else begin
			case (lit_phase)
				tlp_pkg::PH_START: begin
					if (c == tlp_pkg::CH_ZERO) begin
						lit_phase = tlp_pkg::PH_ZERO;
					end else begin
						lit_radix = tlp_pkg::RX_DEC;
						lit_phase = tlp_pkg::PH_BODY;
						fold_char(c);
					end
				end
				tlp_pkg::PH_ZERO: begin
					lit_phase = tlp_pkg::PH_BODY;
					if (c == tlp_pkg::CH_LX || c == tlp_pkg::CH_UX) begin
						lit_radix = tlp_pkg::RX_HEX;
					end else if (c == tlp_pkg::CH_LO || c == tlp_pkg::CH_UO) begin
						lit_radix = tlp_pkg::RX_OCT;
					end else if (c == tlp_pkg::CH_LB || c == tlp_pkg::CH_UB) begin
						lit_radix = tlp_pkg::RX_BIN;
					end else begin
						lit_radix = tlp_pkg::RX_DEC;
						fold_char(tlp_pkg::CH_ZERO);
						fold_char(c);
					end
				end
				default: fold_char(c);
			endcase
		end
	endfunction

	function automatic logic [7:0] pick_char(input tlp_pkg::radix_t rx);
		int k;
		int d;
		k = $urandom_range(0, 99);
		if (k < 80) begin
			case (rx)
				tlp_pkg::RX_HEX: d = $urandom_range(0, 15);
				tlp_pkg::RX_OCT: d = $urandom_range(0, 7);
				tlp_pkg::RX_BIN: d = $urandom_range(0, 1);
				default: d = $urandom_range(0, 9);
			endcase
			// digits outside the base are taken unchecked
			if (k < 4)
				d = $urandom_range(0, 15);
			if (d < 10)
				return 8'(tlp_pkg::CH_ZERO + d);
			return ($urandom_range(0, 1) != 0) ? 8'(tlp_pkg::CH_LA + d - 10) :
				8'(tlp_pkg::CH_UA + d - 10);
		end
		if (k < 88)
			return tlp_pkg::CH_UNDER;
		if (k < 96)
			return (rx != tlp_pkg::RX_DEC || k == 95) ? tlp_pkg::CH_STAR : tlp_pkg::CH_ZERO;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_word(input logic [7:0] c, input logic fin, input logic typed,
			input result_t typed_res);
		logic hs;
		logic done;
		result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		ch <= c;
		end_req <= fin;
		hs = 1'b0;
		while (!hs) begin
			@(negedge clk);
			hs = in_ready;
			@(posedge clk);
		end
		predict_word(c, fin, done, res);
		if (done)
			results_due.push_back(typed ? typed_res : res);
		word_count++;
	endtask

	task automatic send_random_literal();
		int shape;
		int len;
		logic noisy;
		tlp_pkg::radix_t rx;
		shape = $urandom_range(0, 99);
		noisy = ($urandom_range(0, 9) == 0);
		rx = tlp_pkg::RX_DEC;
		if (shape >= 6 && shape < 12) begin
			send_word(tlp_pkg::CH_ZERO, 1'b0, 1'b0, NO_RES);
		end else if (shape >= 12) begin
			case ($urandom_range(0, 7))
				1, 2: begin
					send_word(tlp_pkg::CH_ZERO, 1'b0, 1'b0, NO_RES);
					send_word(($urandom_range(0, 1) != 0) ? tlp_pkg::CH_LX : tlp_pkg::CH_UX,
						1'b0, 1'b0, NO_RES);
					rx = tlp_pkg::RX_HEX;
				end
				3, 4: begin
					send_word(tlp_pkg::CH_ZERO, 1'b0, 1'b0, NO_RES);
					send_word(($urandom_range(0, 1) != 0) ? tlp_pkg::CH_LO : tlp_pkg::CH_UO,
						1'b0, 1'b0, NO_RES);
					rx = tlp_pkg::RX_OCT;
				end
				5, 6: begin
					send_word(tlp_pkg::CH_ZERO, 1'b0, 1'b0, NO_RES);
					send_word(($urandom_range(0, 1) != 0) ? tlp_pkg::CH_LB : tlp_pkg::CH_UB,
						1'b0, 1'b0, NO_RES);
					rx = tlp_pkg::RX_BIN;
				end
				7: send_word(tlp_pkg::CH_ZERO, 1'b0, 1'b0, NO_RES);
				default: rx = tlp_pkg::RX_DEC;
			endcase
			// long bodies make the words wrap
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 70) : $urandom_range(0, 12);
			repeat (len)
				send_word(noisy ? 8'($urandom_range(0, 255)) : pick_char(rx), 1'b0, 1'b0, NO_RES);
		end
		send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_RES);
	endtask

	always @(posedge clk) begin
		ready_tick <= ready_tick + 6'd1;
		if (ready_tick == '0)
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			RDY_ALWAYS: out_ready <= 1'b1;
			RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			RDY_DENSE: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= (ready_tick[2:0] < 3'd5);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("result word with none expected");
				mismatch_count++;
			end else begin
				got_res = results_due.pop_front();
				if (ok !== got_res.ok) begin
					$error("ok: expected %0d, actual %0d", got_res.ok, ok);
					mismatch_count++;
				end
				if (may_be_zero !== got_res.zero) begin
					$error("may_be_zero: expected %h, actual %h", got_res.zero, may_be_zero);
					mismatch_count++;
				end
				if (may_be_one !== got_res.one) begin
					$error("may_be_one: expected %h, actual %h", got_res.one, may_be_one);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < $size(PLAN); i++)
			send_word(PLAN[i].c, PLAN[i].fin, PLAN[i].typed, PLAN[i].res);
		while (word_count < RANDOM_WORDS + $size(PLAN))
			send_random_literal();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("ternary_literal_parser regression: pass");
		else
			$display("ternary_literal_parser regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
